>>> src/qim_coefficient_embed_extract_core_macros.svh
// Assertion macros for the QIM coefficient embed/extract core.
`ifndef QIM_COEFFICIENT_EMBED_EXTRACT_CORE_MACROS_SVH
`define QIM_COEFFICIENT_EMBED_EXTRACT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QIM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qim core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define QIM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qim core: next-cycle check failed");

`endif

>>> src/qim_pkg.sv
// Shared constants and types for the QIM coefficient embed/extract core.
`default_nettype none

package qim_pkg;

  // Number formats
  localparam int COEFF_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int INDEX_WIDTH = 16;
  localparam int STEP_WIDTH  = 31;
  localparam int COUNT_WIDTH = 16;

  // Register port
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_WIDTH = 3;
  localparam int REG_LSB    = 2;

  localparam logic [STEP_WIDTH-1:0]  STEP_RESET  = STEP_WIDTH'(131072);
  localparam logic [STEP_WIDTH-1:0]  STEP_TWO    = STEP_WIDTH'(64'd2 << FRAC_BITS);
  localparam logic [STEP_WIDTH-1:0]  STEP_THRESH = STEP_WIDTH'((64'd1 << FRAC_BITS) / 10000);
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = {COUNT_WIDTH{1'b1}};

  // Divider: magnitude of the coefficient, a few quotient bits per stage
  localparam int NUM_WIDTH  = COEFF_WIDTH - 1;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (NUM_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int NUM_PAD    = DIV_STAGES * DIV_BITS;

  // Center product (2q+1) * step
  localparam int MULT_A     = COEFF_WIDTH + 1;
  localparam int MULT_B     = STEP_WIDTH + 1;
  localparam int PROD_WIDTH = MULT_A + MULT_B;

  localparam logic signed [COEFF_WIDTH-1:0] COEFF_MAX = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
  localparam logic signed [COEFF_WIDTH-1:0] COEFF_MIN = {1'b1, {(COEFF_WIDTH-1){1'b0}}};

  typedef enum logic {
    MODE_EMBED   = 1'b0,
    MODE_EXTRACT = 1'b1
  } qim_mode_t;

  typedef enum logic {
    REG_STEP_SIZE   = 1'b0,
    REG_COEFF_COUNT = 1'b1
  } qim_reg_t;

  // One divider stage: control bits plus the shifting numerator/quotient and the partial remainder
  typedef struct packed {
    qim_mode_t             mode;
    logic                  mbit;
    logic                  ok;
    logic                  neg;
    logic [NUM_PAD-1:0]    num;
    logic [STEP_WIDTH-1:0] rem;
  } qim_div_t;

endpackage

`default_nettype wire

>>> src/qim_coefficient_embed_extract_core.sv
// Top level of the binary QIM coefficient embed/extract core.
//
//   channel   dir   handshake              payload
//   --------  ----  ---------------------  ---------------------------------------------
//   in        in    in_valid / in_stall    mode, coefficient, position, message_bit
//   out       out   out_valid / out_stall  new_coefficient, written, extracted_bit,
//                                          saturated
//   config    in    APB psel/penable       step_size @ 0x0, coeff_count @ 0x4
//
// One transaction per cycle while out_stall is low; the path is DIV_STAGES + 5
// register stages: the pipelined restoring divider (DIV_BITS quotient bits
// per stage) plus input register, index fix-up, cell move, multiply and clamp.
// rst is synchronous and clears only valid bits and config registers; no
// clearing pass. A stall on the output backs up stage by stage: bubbles are
// squeezed out, so input is still taken while any stage is empty.
`default_nettype none

module qim_coefficient_embed_extract_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // config port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [qim_pkg::ADDR_WIDTH-1:0]         paddr,
  input  logic [qim_pkg::DATA_WIDTH-1:0]         pwdata,
  output logic [qim_pkg::DATA_WIDTH-1:0]         prdata,
  output logic                                   pready,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   mode,
  input  logic signed [qim_pkg::COEFF_WIDTH-1:0] coefficient,
  input  logic [qim_pkg::INDEX_WIDTH-1:0]        position,
  input  logic                                   message_bit,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [qim_pkg::COEFF_WIDTH-1:0] new_coefficient,
  output logic                                   written,
  output logic                                   extracted_bit,
  output logic                                   saturated
);
  import qim_pkg::*;

  // Stage map: 0 input reg, 1..DIV_STAGES divider, then A (index fix),
  // B (cell move), C (multiply), O (clamp / output reg).
  localparam int ST_A = DIV_STAGES + 1;
  localparam int ST_B = DIV_STAGES + 2;
  localparam int ST_C = DIV_STAGES + 3;
  localparam int ST_O = DIV_STAGES + 4;
  localparam int NSTG = DIV_STAGES + 5;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [STEP_WIDTH-1:0]  step_size;
  logic [STEP_WIDTH-1:0]  step_eff;    // step with the small-step rule applied
  logic [COUNT_WIDTH-1:0] coeff_count;
  logic                   cfg_wr;
  qim_reg_t               cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = qim_reg_t'(paddr[REG_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size   <= STEP_RESET;
      step_eff    <= STEP_RESET;
      coeff_count <= COUNT_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_STEP_SIZE: begin
          step_size <= pwdata[STEP_WIDTH-1:0];
          // Tiny steps (zero included) fall back to 2.0
          step_eff  <= (pwdata[STEP_WIDTH-1:0] <= STEP_THRESH) ?
                       STEP_TWO : pwdata[STEP_WIDTH-1:0];
        end
        REG_COEFF_COUNT: coeff_count <= pwdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_STEP_SIZE:   prdata = DATA_WIDTH'(step_size);
      REG_COEFF_COUNT: prdata = DATA_WIDTH'(coeff_count);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Valid chain. A stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[ST_O] = !vld[ST_O] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[ST_O];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0 and divider
  // Floor division via one's complement: for x < 0, floor(x/s) = ~((~x)/s),
  // and the floor remainder is s - 1 - r.
  // ---------------------------------------------------------------------------
  qim_div_t                div_q [0:DIV_STAGES];
  logic [COEFF_WIDTH-1:0]  mag_in;

  assign mag_in = coefficient[COEFF_WIDTH-1] ? ~coefficient : coefficient;

  function automatic qim_div_t div_step(input qim_div_t d, input logic [STEP_WIDTH-1:0] s);
    qim_div_t              r;
    logic [STEP_WIDTH:0]   t;
    r = d;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {r.rem, r.num[NUM_PAD-1]};
      if (t >= {1'b0, s}) begin
        r.rem = STEP_WIDTH'(t - {1'b0, s});
        r.num = {r.num[NUM_PAD-2:0], 1'b1};
      end else begin
        r.rem = t[STEP_WIDTH-1:0];
        r.num = {r.num[NUM_PAD-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      div_q[0].mode <= qim_mode_t'(mode);
      div_q[0].mbit <= message_bit;
      div_q[0].ok   <= position < coeff_count;
      div_q[0].neg  <= coefficient[COEFF_WIDTH-1];
      div_q[0].num  <= NUM_PAD'(mag_in[NUM_WIDTH-1:0]);
      div_q[0].rem  <= '0;
    end
    for (int i = 1; i <= DIV_STAGES; i++) begin
      if (adv[i]) div_q[i] <= div_step(div_q[i-1], step_eff);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: signed index q and floor remainder
  // ---------------------------------------------------------------------------
  qim_mode_t                      a_mode;
  logic                           a_bit;
  logic                           a_ok;
  logic signed [COEFF_WIDTH-1:0]  a_q;
  logic [STEP_WIDTH-1:0]          a_rf;
  logic [COEFF_WIDTH-1:0]         q_mag;

  assign q_mag = COEFF_WIDTH'(div_q[DIV_STAGES].num[NUM_WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (adv[ST_A]) begin
      a_mode <= div_q[DIV_STAGES].mode;
      a_bit  <= div_q[DIV_STAGES].mbit;
      a_ok   <= div_q[DIV_STAGES].ok;
      a_q    <= div_q[DIV_STAGES].neg ? ~q_mag : q_mag;
      // s - 1 - r == s + ~r
      a_rf   <= div_q[DIV_STAGES].neg ? step_eff + ~div_q[DIV_STAGES].rem
                                      : div_q[DIV_STAGES].rem;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: parity, move to the nearer cell on mismatch, form 2q+1
  // ---------------------------------------------------------------------------
  qim_mode_t                      b_mode;
  logic                           b_ok;
  logic                           b_xbit;
  logic signed [MULT_A-1:0]       b_m;
  logic                           a_up;
  logic signed [COEFF_WIDTH-1:0]  a_qn;

  // Tie on the cell center moves up
  assign a_up = {a_rf, 1'b0} >= {1'b0, step_eff};

  always_comb begin
    if (a_q[0] != a_bit) begin
      a_qn = a_up ? a_q + COEFF_WIDTH'(1) : a_q - COEFF_WIDTH'(1);
    end else begin
      a_qn = a_q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_B]) begin
      b_mode <= a_mode;
      b_ok   <= a_ok;
      b_xbit <= (a_mode == MODE_EXTRACT) && a_ok && a_q[0];
      b_m    <= {a_qn, 1'b1};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: (2q+1) * step
  // ---------------------------------------------------------------------------
  qim_mode_t                     c_mode;
  logic                          c_ok;
  logic                          c_xbit;
  logic signed [PROD_WIDTH-1:0]  c_prod;
  logic signed [MULT_B-1:0]      step_s;

  assign step_s = {1'b0, step_eff};

  always_ff @(posedge clk) begin
    if (adv[ST_C]) begin
      c_mode <= b_mode;
      c_ok   <= b_ok;
      c_xbit <= b_xbit;
      c_prod <= b_m * step_s;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage O: halve (toward minus infinity), clamp, output register
  // ---------------------------------------------------------------------------
  logic [PROD_WIDTH-2:0]          c_half;
  logic [PROD_WIDTH-COEFF_WIDTH-1:0] c_top;
  logic                           c_ovf;
  logic signed [COEFF_WIDTH-1:0]  c_clamp;
  logic                           c_embed;

  assign c_half  = c_prod[PROD_WIDTH-1:1];
  assign c_top   = c_half[PROD_WIDTH-2:COEFF_WIDTH-1];
  assign c_ovf   = !((&c_top) || !(|c_top));
  assign c_clamp = c_ovf ? (c_half[PROD_WIDTH-2] ? COEFF_MIN : COEFF_MAX)
                         : c_half[COEFF_WIDTH-1:0];
  assign c_embed = (c_mode == MODE_EMBED) && c_ok;

  always_ff @(posedge clk) begin
    if (adv[ST_O]) begin
      new_coefficient <= c_embed ? c_clamp : '0;
      written         <= c_embed;
      saturated       <= c_embed && c_ovf;
      extracted_bit   <= c_xbit;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`include "qim_coefficient_embed_extract_core_macros.svh"

  `QIM_ASSERT_NEXT(a_take_lands, clk, rst, in_valid && !in_stall, vld[0])
  `QIM_ASSERT_NEXT(a_out_held, clk, rst, vld[ST_O] && out_stall, vld[ST_O])
  `QIM_ASSERT_NOW(a_mode_excl, clk, rst, out_valid, !(written && extracted_bit))
  `QIM_ASSERT_NOW(a_sat_embed, clk, rst, out_valid && saturated, written)

endmodule

`default_nettype wire

>>> tb/qim_coefficient_embed_extract_core_tb.sv
// Self-checking testbench for the QIM coefficient embed/extract core.
`timescale 1ns / 1ps

module qim_coefficient_embed_extract_core_tb;
  import qim_pkg::*;

  // Raw Q15.16 step values: anything at or below SMALL_STEP falls back to 2.0
  localparam longint SMALL_STEP = (longint'(1) << FRAC_BITS) / 10000;
  localparam longint TWO_STEP   = longint'(2) << FRAC_BITS;
  localparam longint COEF_HI    = (longint'(1) << 31) - 1;
  localparam longint COEF_LO    = -(longint'(1) << 31);

  localparam int ITEMS_PER_PHASE = 191;
  localparam int NUM_PHASES      = 8;
  localparam int LONG_HOLD       = 400;   // receiver hold-off, in cycles
  localparam int DRAIN_LIMIT     = 5000;  // cycles to wait for stragglers
  localparam int TAIL_CYCLES     = 20;    // longer than the pipeline latency

  // One result transaction as the core should present it
  typedef struct packed {
    logic [31:0] nc;
    logic        w;
    logic        eb;
    logic        sat;
  } qim_result_t;

  // One input transaction; known rows carry a hand-written expectation
  typedef struct {
    qim_mode_t   mode;
    logic [31:0] coef;
    logic [15:0] pos;
    logic        mbit;
    bit          known;
    qim_result_t exp;
  } coef_item_t;

  // Directed row: register setting in force plus the transaction
  typedef struct {
    logic [30:0] step;
    logic [15:0] count;
    coef_item_t  item;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   psel, penable, pwrite;
  logic [ADDR_WIDTH-1:0]  paddr;
  logic [DATA_WIDTH-1:0]  pwdata;
  logic [DATA_WIDTH-1:0]  prdata;
  logic                   pready;
  logic                   in_valid, in_stall;
  qim_mode_t              mode;
  logic signed [31:0]     coefficient;
  logic [15:0]            position;
  logic                   message_bit;
  logic                   out_valid, out_stall;
  logic signed [31:0]     new_coefficient;
  logic                   written, extracted_bit, saturated;

  qim_coefficient_embed_extract_core dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .coefficient     (coefficient),
    .position        (position),
    .message_bit     (message_bit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .new_coefficient (new_coefficient),
    .written         (written),
    .extracted_bit   (extracted_bit),
    .saturated       (saturated)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the register file; only changes while the core is idle
  logic [30:0] cur_step  = STEP_RESET;
  logic [15:0] cur_count = COUNT_RESET;

  coef_item_t  coef_feed[$];        // transactions waiting to be offered
  qim_result_t pending_results[$];  // predicted results, oldest first
  dir_row_t    dir_tab[$];
  coef_item_t  cur_item;
  qim_result_t want;

  int src_idle_pct = 32;
  int dst_idle_pct = 75;
  int hold_reqs = 0;   // bumped by the sequencer to ask for a long hold-off
  int hold_seen = 0;
  int hold_left = 0;

  int errors = 0;
  int n_items = 0, n_results = 0, n_written = 0, n_sat = 0, n_ones = 0;
  int n_stalled = 0, n_cfg_writes = 0;

  // Step actually used by the quantizer for the current register value
  function automatic longint eff_step();
    return (longint'(cur_step) <= SMALL_STEP) ? TWO_STEP : longint'(cur_step);
  endfunction

  // Expected result of one transaction under the current register setting.
  // q = floor(x/step); extract returns its parity, embed fixes the parity
  // (ties on the cell center go up) and returns the cell center, clamped.
  function automatic qim_result_t requantize(qim_mode_t m, logic [31:0] coef,
                                             logic [15:0] pos, logic mbit);
    qim_result_t r;
    longint s, x, q, c;
    r = '0;
    s = eff_step();
    if (pos >= cur_count) return r;
    x = longint'($signed(coef));
    q = x / s;
    if (x % s != 0 && x < 0) q = q - 1;
    if (m == MODE_EXTRACT) begin
      r.eb = q[0];
      return r;
    end
    if (q[0] != mbit) q = (2 * x >= (2 * q + 1) * s) ? q + 1 : q - 1;
    // exact odd multiple of the step, halved toward minus infinity
    c = ((2 * q + 1) * s) >>> 1;
    r.w = 1'b1;
    if (c > COEF_HI) begin
      c = COEF_HI;
      r.sat = 1'b1;
    end else if (c < COEF_LO) begin
      c = COEF_LO;
      r.sat = 1'b1;
    end
    r.nc = c[31:0];
    return r;
  endfunction

  // Random transaction, biased toward cell boundaries and centers of the
  // current step, the coefficient extremes and small values around zero.
  function automatic coef_item_t rand_item();
    coef_item_t it;
    longint s, x;
    s = eff_step();
    it.mode  = $urandom_range(1) ? MODE_EXTRACT : MODE_EMBED;
    it.mbit  = $urandom_range(1);
    it.known = 1'b0;
    it.exp   = '0;
    case ($urandom_range(9))
      0, 1, 2, 3: x = longint'($signed($urandom()));
      4, 5, 6, 7: begin
        x = longint'($signed($urandom())) / s * s;
        case ($urandom_range(4))
          0: ;
          1: x += s / 2;       // exact center when the step is even
          2: x += s / 2 + 1;
          3: x += s - 1;
          default: x += longint'($urandom_range(32'(s - 1)));
        endcase
      end
      8: x = $urandom_range(1) ? COEF_HI - $urandom_range(255)
                               : COEF_LO + $urandom_range(255);
      default: x = longint'($urandom_range(2048)) - 1024;
    endcase
    if (x > COEF_HI) x = COEF_HI;
    if (x < COEF_LO) x = COEF_LO;
    it.coef = x[31:0];
    // mostly in-range positions, the rest anywhere in the 16-bit space
    it.pos = (cur_count != 0 && $urandom_range(9) < 8) ?
             16'($urandom_range(cur_count - 1)) : 16'($urandom());
    return it;
  endfunction

  function automatic void add_row(logic [30:0] step, logic [15:0] count,
                                  qim_mode_t m, logic [31:0] coef,
                                  logic [15:0] pos, logic mbit, bit known,
                                  logic [31:0] nc = 0, logic w = 0,
                                  logic eb = 0, logic sat = 0);
    dir_row_t row;
    row.step       = step;
    row.count      = count;
    row.item.mode  = m;
    row.item.coef  = coef;
    row.item.pos   = pos;
    row.item.mbit  = mbit;
    row.item.known = known;
    row.item.exp   = '{nc: nc, w: w, eb: eb, sat: sat};
    dir_tab.push_back(row);
  endfunction

  task automatic compare_field(string name, logic [31:0] exp, logic [31:0] got);
    if (got !== exp) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, got);
      errors++;
    end
  endtask

  // Sender: offers queued transactions with random gaps. valid stays up and
  // the payload holds until the core takes it. The prediction is made at
  // acceptance, under the register setting in force then.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(cur_item.known ? cur_item.exp :
          requantize(cur_item.mode, cur_item.coef, cur_item.pos, cur_item.mbit));
        n_items++;
      end
      if (in_valid && in_stall) n_stalled++;
      if (!in_valid || !in_stall) begin
        if (coef_feed.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_item = coef_feed.pop_front();
          mode        <= cur_item.mode;
          coefficient <= cur_item.coef;
          position    <= cur_item.pos;
          message_bit <= cur_item.mbit;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall, plus a long hold-off on request, counted here.
  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h/%b/%b/%b", $time,
                   new_coefficient, written, extracted_bit, saturated);
          errors++;
        end else begin
          want = pending_results.pop_front();
          compare_field("new_coefficient", want.nc, new_coefficient);
          compare_field("written", 32'(want.w), 32'(written));
          compare_field("extracted_bit", 32'(want.eb), 32'(extracted_bit));
          compare_field("saturated", 32'(want.sat), 32'(saturated));
          n_written += want.w;
          n_sat     += want.sat;
          n_ones    += want.eb;
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < dst_idle_pct);
      end
    end
  end

  // Register read in APB style; data sampled mid access phase
  task automatic cfg_read(qim_reg_t r);
    logic [31:0] want_val;
    want_val = (r == REG_STEP_SIZE) ? 32'(cur_step) : 32'(cur_count);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_WIDTH'(r) << REG_LSB;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata !== want_val) begin
      $display("%0t: readback of register %s, expected %0h, got %0h", $time,
               r.name(), want_val, prdata);
      errors++;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Register write (setup + access), then read it back
  task automatic cfg_write(qim_reg_t r, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WIDTH'(r) << REG_LSB;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);  // write lands at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_STEP_SIZE) cur_step = val[30:0];
    else cur_count = val[15:0];
    n_cfg_writes++;
    cfg_read(r);
  endtask

  // Wait until everything queued has been taken and every prediction has
  // been matched. Sampled on the falling edge so the posedge processes have
  // settled. Missing results are reported and dropped.
  task automatic wait_idle();
    int spins;
    spins = 0;
    @(negedge clk);
    while (coef_feed.size() != 0 || in_valid) @(negedge clk);
    while (pending_results.size() != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results, got none", $time,
               pending_results.size());
      errors += pending_results.size();
      pending_results.delete();
    end
  endtask

  // Sequencer
  initial begin
    logic [31:0] phase_step[NUM_PHASES];
    logic [31:0] phase_count[NUM_PHASES];

    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    mode        = MODE_EMBED;
    coefficient = '0;
    position    = '0;
    message_bit = 1'b0;
    out_stall   = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Registers come up at 2.0 and 65535
    cfg_read(REG_STEP_SIZE);
    cfg_read(REG_COEFF_COUNT);

    // Directed cases. Known rows: reset setting, extremes, rejected positions.
    // Step 2.0: max coefficient sits in cell 16383, min in cell -16384.
    add_row(STEP_RESET, 65535, MODE_EXTRACT, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(STEP_RESET, 65535, MODE_EMBED, 0, 0, 0, 1, 32'h0001_0000, 1, 0, 0);
    add_row(STEP_RESET, 65535, MODE_EMBED, 0, 1, 1, 1, 32'hFFFF_0000, 1, 0, 0);
    add_row(STEP_RESET, 65535, MODE_EMBED, 32'h7FFF_FFFF, 65534, 1, 1,
            32'h7FFF_0000, 1, 0, 0);
    // moving up from the top cell overflows
    add_row(STEP_RESET, 65535, MODE_EMBED, 32'h7FFF_FFFF, 3, 0, 1,
            32'h7FFF_FFFF, 1, 0, 1);
    // moving down from the bottom cell underflows
    add_row(STEP_RESET, 65535, MODE_EMBED, 32'h8000_0000, 4, 1, 1,
            32'h8000_0000, 1, 0, 1);
    add_row(STEP_RESET, 65535, MODE_EMBED, 32'h8000_0000, 5, 0, 1,
            32'h8001_0000, 1, 0, 0);
    add_row(STEP_RESET, 65535, MODE_EXTRACT, 32'h7FFF_FFFF, 6, 0, 1, 0, 0, 1, 0);
    add_row(STEP_RESET, 65535, MODE_EXTRACT, 32'h8000_0000, 7, 1, 1, 0, 0, 0, 0);
    // position equal to coeff_count is rejected in both modes
    add_row(STEP_RESET, 65535, MODE_EMBED, 12345, 65535, 1, 1, 0, 0, 0, 0);
    add_row(STEP_RESET, 65535, MODE_EXTRACT, 32'h0003_0000, 65535, 1, 1,
            0, 0, 0, 0);
    // coefficient on a cell center with the wrong parity: q moves up
    add_row(STEP_RESET, 65535, MODE_EMBED, 32'h0001_0000, 16'h5A5A, 1, 0);
    add_row(STEP_RESET, 65535, MODE_EXTRACT, -1, 16'hA5A5, 0, 0);
    // zero and threshold steps fall back to 2.0
    add_row(0, 65535, MODE_EMBED, 32'h0005_0000, 10, 1, 0);
    add_row(0, 65535, MODE_EXTRACT, -32'sh1_0000, 11, 0, 0);
    add_row(6, 65535, MODE_EMBED, 100, 12, 0, 0);
    // smallest real step, odd: half-LSB centers round toward minus infinity
    add_row(7, 65535, MODE_EMBED, 0, 13, 0, 0);
    add_row(7, 65535, MODE_EMBED, -10, 14, 1, 0);
    add_row(7, 65535, MODE_EXTRACT, -8, 15, 0, 0);
    // largest step: only a handful of cells, both ends clamp
    add_row(31'h7FFF_FFFF, 65535, MODE_EMBED, 32'h7FFF_FFFF, 16, 1, 0);
    add_row(31'h7FFF_FFFF, 65535, MODE_EMBED, 32'h8000_0000, 17, 0, 0);
    add_row(31'h7FFF_FFFF, 65535, MODE_EMBED, 0, 18, 1, 0);
    // coeff_count of zero rejects everything
    add_row(STEP_RESET, 0, MODE_EMBED, 32'h0000_1234, 0, 1, 1, 0, 0, 0, 0);
    add_row(STEP_RESET, 0, MODE_EXTRACT, 32'h0003_0000, 0, 0, 1, 0, 0, 0, 0);
    add_row(STEP_RESET, 1, MODE_EMBED, 32'h0003_0000, 0, 0, 0);
    add_row(STEP_RESET, 1, MODE_EXTRACT, 32'h0003_0000, 1, 1, 1, 0, 0, 0, 0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].step != cur_step || dir_tab[i].count != cur_count) begin
        wait_idle();
        if (dir_tab[i].step != cur_step)
          cfg_write(REG_STEP_SIZE, 32'(dir_tab[i].step));
        if (dir_tab[i].count != cur_count)
          cfg_write(REG_COEFF_COUNT, 32'(dir_tab[i].count));
      end
      coef_feed.push_back(dir_tab[i].item);
    end

    // Random phases: each under its own register setting
    phase_step[0] = 32'h0001_8000;  phase_count[0] = 65535;
    phase_step[1] = 7;              phase_count[1] = 1000;
    phase_step[2] = 32'h7FFF_FFFF;  phase_count[2] = 65535;
    phase_step[3] = 0;              phase_count[3] = 300;
    phase_step[4] = 6;              phase_count[4] = 65535;
    phase_step[5] = $urandom_range(32'h0010_0000, 7);
    phase_count[5] = $urandom_range(65535);
    phase_step[6] = 32'h0001_0001;  phase_count[6] = 40000;
    phase_step[7] = $urandom_range(32'h7FFF_FFFF, 7);
    phase_count[7] = 65535;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      // sender idles 32% / receiver 75%, then swapped, then no idling
      src_idle_pct = (p < 3) ? 32 : (p < 6) ? 75 : 0;
      dst_idle_pct = (p < 3) ? 75 : (p < 6) ? 32 : 0;
      cfg_write(REG_STEP_SIZE, phase_step[p]);
      cfg_write(REG_COEFF_COUNT, phase_count[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // sender pause: let every outstanding result come back first
        if (p == 4 && k == ITEMS_PER_PHASE / 2) wait_idle();
        coef_feed.push_back(rand_item());
      end
      // long receiver hold-off while the sender keeps offering: the
      // pipeline fills and the core must stall its input
      if (p == 1) hold_reqs++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d transactions in, %0d results (%0d written, %0d clamped, %0d ones read)",
             n_items, n_results, n_written, n_sat, n_ones);
    $display("Summary: %0d register writes, %0d cycles of input backpressure, %0d errors",
             n_cfg_writes, n_stalled, errors);
    if (errors == 0) begin
      $display("** qim_coefficient_embed_extract_core: PASSED **");
    end else begin
      $display("** qim_coefficient_embed_extract_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
    $display("** qim_coefficient_embed_extract_core: FAILED **");
    $finish;
  end

endmodule
